// ----- rtl/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants of the triangle tangent basis block.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int IDX_W            = 10;
	localparam int CRD_W            = 24;
	localparam int DLT_W            = CRD_W + 1;
	localparam int PRD_W            = 2 * DLT_W;
	localparam int NUM_W            = PRD_W + 1;
	localparam int OUT_W            = 32;
	localparam int FRAC_W           = 16;
	localparam int DIV_STEPS        = OUT_W - 1;
	localparam int DIV_LAT          = DIV_STEPS + 3;
	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int QUEUE_DEPTH      = 4;
	localparam int IN_DATA_W        = 160;
	localparam int OUT_DATA_W       = 192;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TRI  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		FS_FREE,
		FS_RD_B,
		FS_RD_C
	} fstate_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] v;
		logic signed [CRD_W-1:0] u;
		logic signed [CRD_W-1:0] z;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] x;
	} vertex_t;

	typedef struct packed {
		vertex_t c;
		vertex_t b;
		vertex_t a;
	} corners_t;

	typedef struct packed {
		logic     vld;
		corners_t corners;
	} qpush_t;

endpackage

// ----- rtl/triangle_tangent_basis.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Per-triangle tangent and bitangent from a vertex store of Q8.16 positions
// and texture coordinates, emitted as saturated Q16.16 vectors.
// ----------------------------------------------------------------------------
// A vertex load gives no result. A triangle is gathered in the front with
// one read of the single-port vertex store per corner, and no new beat is
// accepted until its third corner has been read. A result is presented
// after the corner reads, the queue push, the delta, product and determinant
// registers, and a 34-stage divider made of two setup stages, 31 stages that
// each yield one quotient bit, and an output register. A four-entry queue
// lets vertex loads continue while the output is stalled, until four
// triangles are waiting.
module triangle_tangent_basis import ttb_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// vertex_slot, pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
	output logic [OUT_DATA_W-1:0] m_tdata,
	// degenerate
	output logic                  m_tuser
);

	qpush_t   q_push;
	corners_t q_head;
	logic     q_pop;
	logic     q_empty;
	logic     q_full;

	ttb_front #(
		.VERTEX_COUNT (VERTEX_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (q_pop),
		.push     (q_push)
	);

	ttb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	ttb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.vld |-> !q_full)
		else $error("Triangle pushed into a full queue.");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("Queue popped while empty.");

	a_tri_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == ACT_TRI) |=> !s_tready)
		else $error("Beat accepted while corners were being read.");

endmodule

// ----- rtl/ttb_queue.sv -----
// ----------------------------------------------------------------------------
// ttb_queue
// Small queue of gathered triangles between the front and the back.
// ----------------------------------------------------------------------------
module ttb_queue import ttb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  qpush_t   push,
	input  logic     pop,
	output corners_t head,
	output logic     empty,
	output logic     full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	corners_t       mem_q [0:DEPTH-1];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.vld) begin
			mem_q[wr_q] <= push.corners;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.vld) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push.vld) - CW'(pop);
		end
	end

endmodule

// ----- rtl/ttb_front.sv -----
// ----------------------------------------------------------------------------
// ttb_front
// Accepts beats, writes vertices into the single-port vertex store and
// gathers the three corners of each triangle for the queue.
// ----------------------------------------------------------------------------
module ttb_front import ttb_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 pop,
	output qpush_t               push
);

	localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fstate_t          st_q;
	fstate_t          st_nxt;
	action_t          act;
	logic             acc;
	logic             re;
	logic             we;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] ca;
	logic [IDX_W-1:0] cb_q;
	logic [IDX_W-1:0] cc_q;
	logic [CW-1:0]    cnt_q;
	logic             rok_q;
	logic             push_q;
	vertex_t          vin;
	vertex_t          rd_q;
	vertex_t          rdv;
	vertex_t          va_q;
	vertex_t          vb_q;
	vertex_t          mem [0:VERTEX_COUNT-1];

	function automatic logic in_rng(input logic [IDX_W-1:0] i);
		in_rng = (32'(i) < 32'(VERTEX_COUNT));
	endfunction

	assign act   = action_t'(s_tuser);
	assign slot  = s_tdata[9:0];
	assign vin.x = s_tdata[33:10];
	assign vin.y = s_tdata[57:34];
	assign vin.z = s_tdata[81:58];
	assign vin.u = s_tdata[105:82];
	assign vin.v = s_tdata[129:106];
	assign ca    = s_tdata[139:130];

	assign s_tready = (st_q == FS_FREE) && (cnt_q < CW'(QUEUE_DEPTH));
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			FS_FREE: begin
				if (acc && act == ACT_TRI) begin
					st_nxt = FS_RD_B;
				end
			end
			FS_RD_B: st_nxt = FS_RD_C;
			FS_RD_C: st_nxt = FS_FREE;
			default: st_nxt = FS_FREE;
		endcase
	end

	always_comb begin
		idx = slot;
		re  = 1'b0;
		we  = 1'b0;
		unique case (st_q)
			FS_FREE: begin
				idx = (act == ACT_TRI) ? ca : slot;
				re  = acc && act == ACT_TRI;
				we  = acc && act == ACT_LOAD && in_rng(slot);
			end
			FS_RD_B: begin
				idx = cb_q;
				re  = 1'b1;
			end
			FS_RD_C: begin
				idx = cc_q;
				re  = 1'b1;
			end
			default: begin
				idx = slot;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[AW'(idx)] <= vin;
		end else if (re) begin
			rd_q <= mem[AW'(idx)];
		end
	end

	assign rdv = rok_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (re) begin
			rok_q <= in_rng(idx);
		end
		if (acc) begin
			cb_q <= s_tdata[149:140];
			cc_q <= s_tdata[159:150];
		end
		if (st_q == FS_RD_B) begin
			va_q <= rdv;
		end
		if (st_q == FS_RD_C) begin
			vb_q <= rdv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= FS_FREE;
			push_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			st_q   <= st_nxt;
			push_q <= (st_q == FS_RD_C);
			cnt_q  <= cnt_q + CW'(acc && act == ACT_TRI) - CW'(pop);
		end
	end

	assign push.vld       = push_q;
	assign push.corners.a = va_q;
	assign push.corners.b = vb_q;
	assign push.corners.c = rdv;

endmodule

// ----- rtl/ttb_div.sv -----
// ----------------------------------------------------------------------------
// ttb_div
// Pipelined signed fixed-point divider, one quotient bit per stage, with
// truncation toward zero and saturation to the output width.
// ----------------------------------------------------------------------------
module ttb_div import ttb_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [NUM_W-1:0] den,
	output logic [OUT_W-1:0]        quo
);

	localparam int RW     = NUM_W + 1;
	localparam int SAT_SH = OUT_W - 1 - FRAC_W;

	logic                 neg_a;
	logic [NUM_W-1:0]     na_a;
	logic [NUM_W-1:0]     da_a;
	logic [RW-1:0]        rem_s [0:DIV_STEPS-1];
	logic [DIV_STEPS-1:0] nb_s  [0:DIV_STEPS-1];
	logic [NUM_W-1:0]     d_s   [0:DIV_STEPS-1];
	logic [DIV_STEPS-1:0] q_s   [0:DIV_STEPS];
	logic                 neg_s [0:DIV_STEPS];
	logic                 sat_s [0:DIV_STEPS];
	logic [OUT_W-1:0]     quo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_a    <= num[NUM_W-1] ^ den[NUM_W-1];
			na_a     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			da_a     <= den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
			sat_s[0] <= {{SAT_SH{1'b0}}, na_a} >= {da_a, {SAT_SH{1'b0}}};
			rem_s[0] <= RW'(na_a >> SAT_SH);
			nb_s[0]  <= {na_a[SAT_SH-1:0], {FRAC_W{1'b0}}};
			q_s[0]   <= '0;
			d_s[0]   <= da_a;
			neg_s[0] <= neg_a;
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [RW-1:0] t;
		logic          ge;

		assign t  = {rem_s[i][RW-2:0], nb_s[i][DIV_STEPS-1]};
		assign ge = (t >= {1'b0, d_s[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1]   <= {q_s[i][DIV_STEPS-2:0], ge};
				neg_s[i+1] <= neg_s[i];
				sat_s[i+1] <= sat_s[i];
			end
		end

		if (i < DIV_STEPS - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= ge ? t - {1'b0, d_s[i]} : t;
					nb_s[i+1]  <= {nb_s[i][DIV_STEPS-2:0], 1'b0};
					d_s[i+1]   <= d_s[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[DIV_STEPS]) begin
				quo_q <= neg_s[DIV_STEPS] ? {1'b1, {(OUT_W-1){1'b0}}} :
					{1'b0, {(OUT_W-1){1'b1}}};
			end else begin
				quo_q <= neg_s[DIV_STEPS] ? -{1'b0, q_s[DIV_STEPS]} :
					{1'b0, q_s[DIV_STEPS]};
			end
		end
	end

	assign quo = quo_q;

endmodule

// ----- rtl/ttb_back.sv -----
// ----------------------------------------------------------------------------
// ttb_back
// Takes gathered triangles from the queue, forms edge and UV deltas, the
// Cramer numerators and the determinant, and divides them out.
// ----------------------------------------------------------------------------
module ttb_back import ttb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  corners_t              head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	logic                    en;
	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	logic signed [DLT_W-1:0] dp1_s1 [0:2];
	logic signed [DLT_W-1:0] dp2_s1 [0:2];
	logic signed [DLT_W-1:0] du1_s1;
	logic signed [DLT_W-1:0] du2_s1;
	logic signed [DLT_W-1:0] dv1_s1;
	logic signed [DLT_W-1:0] dv2_s1;
	logic signed [PRD_W-1:0] p1_s2 [0:2];
	logic signed [PRD_W-1:0] p2_s2 [0:2];
	logic signed [PRD_W-1:0] p3_s2 [0:2];
	logic signed [PRD_W-1:0] p4_s2 [0:2];
	logic signed [PRD_W-1:0] pd1_s2;
	logic signed [PRD_W-1:0] pd2_s2;
	logic signed [NUM_W-1:0] det_s3;
	logic signed [NUM_W-1:0] num_s3 [0:5];
	logic [OUT_W-1:0]        quo [0:5];
	logic                    vline_q [0:DIV_LAT-1];
	logic                    dline_q [0:DIV_LAT-1];
	logic [OUT_DATA_W-1:0]   res;

	function automatic logic signed [DLT_W-1:0] dlt(input logic signed [CRD_W-1:0] p,
		input logic signed [CRD_W-1:0] q);
		dlt = {p[CRD_W-1], p} - {q[CRD_W-1], q};
	endfunction

	function automatic logic signed [NUM_W-1:0] dif(input logic signed [PRD_W-1:0] p,
		input logic signed [PRD_W-1:0] q);
		dif = {p[PRD_W-1], p} - {q[PRD_W-1], q};
	endfunction

	assign m_tvalid = vline_q[DIV_LAT-1];
	assign en       = !m_tvalid || m_tready;
	assign pop      = en && !empty;

	always_ff @(posedge clk) begin
		if (en) begin
			dp1_s1[0] <= dlt(head.b.x, head.a.x);
			dp1_s1[1] <= dlt(head.b.y, head.a.y);
			dp1_s1[2] <= dlt(head.b.z, head.a.z);
			dp2_s1[0] <= dlt(head.c.x, head.a.x);
			dp2_s1[1] <= dlt(head.c.y, head.a.y);
			dp2_s1[2] <= dlt(head.c.z, head.a.z);
			du1_s1    <= dlt(head.b.u, head.a.u);
			du2_s1    <= dlt(head.c.u, head.a.u);
			dv1_s1    <= dlt(head.b.v, head.a.v);
			dv2_s1    <= dlt(head.c.v, head.a.v);
			pd1_s2    <= du1_s1 * dv2_s1;
			pd2_s2    <= dv1_s1 * du2_s1;
			det_s3    <= dif(pd1_s2, pd2_s2);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		always_ff @(posedge clk) begin
			if (en) begin
				p1_s2[k]    <= dp1_s1[k] * dv2_s1;
				p2_s2[k]    <= dp2_s1[k] * dv1_s1;
				p3_s2[k]    <= dp2_s1[k] * du1_s1;
				p4_s2[k]    <= dp1_s1[k] * du2_s1;
				num_s3[k]   <= dif(p1_s2[k], p2_s2[k]);
				num_s3[k+3] <= dif(p3_s2[k], p4_s2[k]);
			end
		end
	end

	for (genvar j = 0; j < 6; j++) begin : g_lane
		ttb_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3[j]),
			.den (det_s3),
			.quo (quo[j])
		);
		assign res[j*OUT_W +: OUT_W] = quo[j];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dline_q[0] <= (det_s3 == '0);
			for (int i = 1; i < DIV_LAT; i++) begin
				dline_q[i] <= dline_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vline_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1       <= pop;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			vline_q[0] <= v_s3;
			for (int i = 1; i < DIV_LAT; i++) begin
				vline_q[i] <= vline_q[i-1];
			end
		end
	end

	assign m_tuser = dline_q[DIV_LAT-1];
	assign m_tdata = m_tuser ? '0 : res;

endmodule
